>>> rtl/core/ccr_pkg.sv
// shared types, constants and helpers of the closed catmull-rom evaluator
// no dependencies; imported by every module of the block
package ccr_pkg;

  localparam int PARAM_W     = 24;  // width of the curve parameter field
  localparam int COORD_W     = 32;
  localparam int ACC_W       = 38;  // holds every blend term and partial result
  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] POINT_COUNT_RST = 5'd4;
  localparam logic       REG_POINT_COUNT = 1'b0;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // lane schedule: product of one step is rounded in the next
  localparam logic [2:0] STEP_MUL_A  = 3'd0;
  localparam logic [2:0] STEP_MUL_A3 = 3'd1;
  localparam logic [2:0] STEP_MUL_S1 = 3'd2;
  localparam logic [2:0] STEP_MUL_U1 = 3'd3;
  localparam logic [2:0] STEP_MUL_S2 = 3'd4;
  localparam logic [2:0] STEP_LAST   = 3'd5;

  typedef struct packed {
    logic                      req_type;
    logic [3:0]                point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PARAM_W-1:0]        curve_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tan_x;
    logic signed [COORD_W-1:0] tan_y;
    logic signed [COORD_W-1:0] tan_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic       load;
    logic       run;
    logic [2:0] step;
  } lane_ctl_t;

  // (v + 1) >> 1, then clamp to the 32-bit signed range
  function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ACC_W'(1)) >>> 1;
    if ((&t[ACC_W-1:COORD_W-1]) || !(|t[ACC_W-1:COORD_W-1])) begin
      return t[COORD_W-1:0];
    end else if (t[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/core/closed_catmull_rom_evaluator_unit.sv
// top level of the closed catmull-rom evaluator: point count register on an
// apb-style port, front, queue and back; depends on ccr_pkg and all ccr_ modules
//
// usage:
//   in channel: drive in_item and raise start; the item is taken at a clock edge
//   with start high and busy low. a load item (req_type 0) writes one control
//   point, an evaluate item (req_type 1) returns one result.
//   out channel: out_result is valid for exactly one cycle while out_strobe is
//   high; the receiver cannot stall it, so it must take every beat.
//   config: point_count at byte address 0, written with a setup and an access
//   cycle; pready is always high. write it only while the block is idle.
// timing:
//   the front reduces the segment number bit by bit over the 24 - FRAC_BITS
//   integer bits, then writes the queue; the back takes one evaluation at a
//   time (pop, four serial point reads on the single memory read port,
//   coefficients, six steps of the per-axis multiplier, result register) and
//   pops no new item until its result is registered, so its multiplier
//   schedule sets the sustained rate. loads go straight into the queue and
//   are written to the point table as the back pops them.
// reset: control state clears and point_count returns to 4; the point table is
//   not cleared and must be loaded before it is evaluated.
module closed_catmull_rom_evaluator_unit
  import ccr_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int EW = IW + $bits(in_item_t);

  logic [4:0]  point_count_r;
  logic [IW:0] seg_count;
  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINT_COUNT) ? {27'd0, point_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_POINT_COUNT) begin
      point_count_r <= pwdata[4:0];
    end
  end

  // zero counts as one, anything above the table depth is clamped
  always_comb begin
    if (point_count_r == '0) begin
      seg_count = (IW+1)'(1);
    end else if (32'(point_count_r) > MAX_POINTS) begin
      seg_count = (IW+1)'(MAX_POINTS);
    end else begin
      seg_count = (IW+1)'(point_count_r);
    end
  end

  ccr_front #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .seg_count(seg_count), .q_push(q_push), .q_wdata(q_wdata), .q_full(q_full)
  );

  ccr_queue #(.WIDTH(EW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  ccr_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .seg_count(seg_count), .q_rdata(q_rdata),
    .q_empty(q_empty), .q_pop(q_pop), .out_strobe(out_strobe), .out_result(out_result)
  );

endmodule

>>> rtl/core/ccr_queue.sv
// two-entry queue between the front and back parts
// depends on ccr_pkg for the depth
module ccr_queue
  import ccr_pkg::*;
#(
  parameter int WIDTH = 129
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count out of range");

endmodule

>>> rtl/core/ccr_front.sv
// front part: accepts items, reduces the parameter's integer part modulo the
// point count one bit per cycle and queues work for the back; uses ccr_pkg
module ccr_front
  import ccr_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  output logic                                         busy,
  input  in_item_t                                     in_item,
  input  logic [$clog2(MAX_POINTS):0]                  seg_count,
  output logic                                         q_push,
  output logic [$clog2(MAX_POINTS)+$bits(in_item_t)-1:0] q_wdata,
  input  logic                                         q_full
);

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int QWS   = (PARAM_W - FRAC_BITS > 0) ? PARAM_W - FRAC_BITS : 1;
  localparam int CNT_W = $clog2(QWS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [QWS-1:0]   quo_r, quo_nxt;
  logic [IW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic           accept;
  logic [QWS-1:0] int_part;
  logic [IW:0]    trial;

  assign busy     = (state_r != ST_IDLE) || q_full;
  assign accept   = start && !busy;
  assign int_part = QWS'({1'b0, in_item.curve_param} >> FRAC_BITS);
  assign trial    = {rem_r, quo_r[QWS-1]};

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    q_wdata   = {rem_r, item_r};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.req_type == REQ_LOAD) begin
            // loads go straight through, segment field unused
            q_push  = 1'b1;
            q_wdata = {{IW{1'b0}}, in_item};
          end else begin
            item_nxt  = in_item;
            quo_nxt   = int_part;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(QWS - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // restoring remainder step
        if (trial >= seg_count) begin
          rem_nxt = IW'(trial - seg_count);
        end else begin
          rem_nxt = IW'(trial);
        end
        quo_nxt = quo_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      item_r  <= item_nxt;
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/ccr_lane.sv
// one axis of the evaluator: blend coefficients and a shared multiplier that
// forms position and derivative by nested rounding steps; uses ccr_pkg
module ccr_lane
  import ccr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic [FRAC_BITS-1:0]      frac,
  input  logic signed [COORD_W-1:0] p0,
  input  logic signed [COORD_W-1:0] p1,
  input  logic signed [COORD_W-1:0] p2,
  input  logic signed [COORD_W-1:0] p3,
  output logic signed [COORD_W-1:0] pos,
  output logic signed [COORD_W-1:0] tan
);

  localparam int PW = ACC_W + FRAC_BITS + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [ACC_W-1:0] a_r, b_r, c_r, d_r, s_r, u_r;
  logic signed [PW-1:0]    prod_r;

  logic signed [ACC_W-1:0] e0, e1, e2, e3;
  logic signed [ACC_W-1:0] mul_op, rnd;
  logic signed [PW-1:0]    rsum;

  assign e0 = ACC_W'(p0);
  assign e1 = ACC_W'(p1);
  assign e2 = ACC_W'(p2);
  assign e3 = ACC_W'(p3);

  always_comb begin
    case (ctl.step)
      STEP_MUL_A:  mul_op = a_r;
      STEP_MUL_A3: mul_op = a_r + (a_r <<< 1);
      STEP_MUL_S1: mul_op = s_r;
      STEP_MUL_U1: mul_op = u_r;
      default:     mul_op = s_r;
    endcase
  end

  // round half up of the previous step's product
  assign rsum = prod_r + HALF;
  assign rnd  = ACC_W'(rsum >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_op) * $signed({1'b0, frac});
    if (ctl.load) begin
      a_r <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
      b_r <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c_r <= e2 - e0;
      d_r <= e1 <<< 1;
    end
    if (ctl.run) begin
      case (ctl.step)
        STEP_MUL_A3: s_r <= rnd + b_r;
        STEP_MUL_S1: u_r <= rnd + (b_r <<< 1);
        STEP_MUL_U1: s_r <= rnd + c_r;
        STEP_MUL_S2: u_r <= rnd + c_r;
        STEP_LAST:   s_r <= rnd + d_r;
        default: ;
      endcase
    end
  end

  assign pos = half_sat(s_r);
  assign tan = half_sat(u_r);

endmodule

>>> rtl/core/ccr_back.sv
// back part: control point memory, point fetch, three axis lanes and the
// result register; uses ccr_pkg and ccr_lane
module ccr_back
  import ccr_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [$clog2(MAX_POINTS):0]                  seg_count,
  input  logic [$clog2(MAX_POINTS)+$bits(in_item_t)-1:0] q_rdata,
  input  logic                                         q_empty,
  output logic                                         q_pop,
  output logic                                         out_strobe,
  output out_item_t                                    out_result
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int ITEM_W = $bits(in_item_t);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_COEF, ST_EVAL, ST_FIN} state_t;

  state_t    state_r;
  logic [2:0] rcnt_r;
  logic [2:0] step_r;
  logic       out_strobe_r;
  out_item_t  out_result_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [IW-1:0] idx_r [4];
  point_t        p_r [4];

  point_t mem [MAX_POINTS];
  point_t rd_data_r;

  in_item_t      head;
  logic [IW-1:0] seg, ip1, ip2, im1, rd_addr;
  logic          wr_en;
  lane_ctl_t     lctl;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, tan_x, tan_y, tan_z;

  assign head  = in_item_t'(q_rdata[ITEM_W-1:0]);
  assign seg   = q_rdata[ITEM_W+IW-1:ITEM_W];
  assign q_pop = (state_r == ST_IDLE) && !q_empty;
  assign wr_en = q_pop && (head.req_type == REQ_LOAD) &&
                 (32'(head.point_index) < MAX_POINTS);

  // neighbor indices with wrap-around
  assign ip1 = (({1'b0, seg} + (IW+1)'(1)) == seg_count) ? '0 : seg + IW'(1);
  assign ip2 = (({1'b0, ip1} + (IW+1)'(1)) == seg_count) ? '0 : ip1 + IW'(1);
  assign im1 = (seg == '0) ? IW'(seg_count - (IW+1)'(1)) : seg - IW'(1);

  assign rd_addr = idx_r[rcnt_r[1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(head.point_index)] <= '{x: head.coord_x, y: head.coord_y, z: head.coord_z};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rcnt_r       <= '0;
      step_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && head.req_type == REQ_EVAL) begin
            idx_r[0] <= im1;
            idx_r[1] <= seg;
            idx_r[2] <= ip1;
            idx_r[3] <= ip2;
            frac_r   <= head.curve_param[FRAC_BITS-1:0];
            rcnt_r   <= '0;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          // read data is registered, so it arrives in the cycle after its address
          if (rcnt_r != '0) begin
            p_r[rcnt_r[1:0] - 2'd1] <= rd_data_r;
          end
          rcnt_r <= rcnt_r + 3'd1;
          if (rcnt_r == 3'd4) begin
            state_r <= ST_COEF;
          end
        end
        ST_COEF: begin
          step_r  <= STEP_MUL_A;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          step_r <= step_r + 3'd1;
          if (step_r == STEP_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_result_r <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                            tan_x: tan_x, tan_y: tan_y, tan_z: tan_z};
          out_strobe_r <= 1'b1;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign lctl = '{load: (state_r == ST_COEF), run: (state_r == ST_EVAL), step: step_r};

  ccr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .ctl(lctl), .frac(frac_r),
    .p0(p_r[0].x), .p1(p_r[1].x), .p2(p_r[2].x), .p3(p_r[3].x),
    .pos(pos_x), .tan(tan_x)
  );
  ccr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .ctl(lctl), .frac(frac_r),
    .p0(p_r[0].y), .p1(p_r[1].y), .p2(p_r[2].y), .p3(p_r[3].y),
    .pos(pos_y), .tan(tan_y)
  );
  ccr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .ctl(lctl), .frac(frac_r),
    .p0(p_r[0].z), .p1(p_r[1].z), .p2(p_r[2].z), .p3(p_r[3].z),
    .pos(pos_z), .tan(tan_z)
  );

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held longer than one cycle");
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finished evaluation");
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rcnt_r <= 3'd4))
    else $error("point fetch counter overran");

endmodule
